/* sv/ast_pkg.sv */
// Package: types, constants and op codes of the alert slot tracker.
`default_nettype none
package ast_pkg;
  localparam int NumSlotsDef = 8;
  localparam logic [19:0] FloorRst = 20'd10000;
  localparam logic [19:0] MaxAgeRst = 20'd10000;
  localparam int SlotW = 24 + 8 + 32 + 32 + 32 + 2 + 1 + 32 + 1;

  typedef enum logic [2:0] {
    OP_OBSERVE = 3'd0,
    OP_WITHDRAW = 3'd1,
    OP_DISMISS = 3'd2,
    OP_FORGET = 3'd3,
    OP_QUERY = 3'd4
  } op_t;

  typedef enum logic [0:0] {
    REG_FLOOR = 1'b0,
    REG_MAX_AGE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [2:0] op;
    logic [31:0] now_ms;
    logic [23:0] addr;
    logic [7:0] addr_qual;
    logic [31:0] obs_key;
    logic [31:0] obs_time_ms;
    logic [31:0] forget_after_ms;
    logic [1:0] level;
  } in_item_t;

  typedef struct packed {
    logic notify;
    logic slot_dismissed;
    logic [1:0] ann_level;
    logic all_dismissed;
  } out_item_t;

  typedef struct packed {
    logic [23:0] addr;
    logic [7:0] tbl;
    logic [31:0] obs_key;
    logic [31:0] seen_ms;
    logic [31:0] keep_ms;
    logic [1:0] level;
    logic falling;
    logic [31:0] falling_since;
    logic dismissed;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND,
    ST_OBS_RD,
    ST_OBS_WR,
    ST_SWEEP_RD,
    ST_SWEEP,
    ST_STAT_RD,
    ST_STAT,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

/* sv/ast_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module ast_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0] addr,
  input  wire logic [Width-1:0] wdata,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* sv/alert_slot_tracker.sv */
// Alert slot tracker top level: slot table walk, level logic and config port.
// Usage: one input channel (in_valid/in_stall/in_data) carries an op with its
// target key, times and assessed level; one output channel
// (out_valid/out_stall/out_data) returns exactly one result per op.
// Slot payload lies in one single-port RAM of NUM_SLOTS entries; used bits
// are flip-flops. Each op walks the table slot by slot (read a slot, then
// use its data); an observe search ends early on a key hit. Withdraw,
// dismiss and forget sweep every slot, while query and unused ops run only
// the status pass. The walks over the slot RAM set the rate. The status
// pass (announced level, all dismissed) always runs after the op. Input
// stall is high whenever an op is in work or its result waits. While
// out_stall is high the result holds and no new op is taken. Reset clears
// the used bits and sets the config registers to their defaults at once, so
// the block takes items in the first cycle after reset. Configuration goes
// over the APB-style port (floor at 0x0, max age at 0x4); the user must use
// it only while the block is idle, which the block itself does not enforce.
`default_nettype none
module alert_slot_tracker
  import ast_pkg::*;
#(
  parameter int NUM_SLOTS = NumSlotsDef
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire ast_pkg::in_item_t in_data,
  output logic out_valid,
  input  wire logic out_stall,
  output ast_pkg::out_item_t out_data,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int IdxW = $clog2(NUM_SLOTS > 1 ? NUM_SLOTS : 2);

  logic [19:0] floor_ms, max_age_ms;
  state_t state, state_next;
  in_item_t cur;
  logic [NUM_SLOTS-1:0] used;
  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] ram_addr;
  logic ram_we;
  slot_t ram_wdata, rd;
  logic [IdxW-1:0] sel;
  logic have_free, have_old;
  logic [IdxW-1:0] free_i, old_i;
  logic [31:0] old_age;
  logic fresh_claim;
  logic [1:0] ann;
  logic any_lvl, all_dis;
  logic notify_r, sdis_r;
  logic last;

  // config port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      floor_ms <= FloorRst;
      max_age_ms <= MaxAgeRst;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_FLOOR: floor_ms <= pwdata[19:0];
        REG_MAX_AGE: max_age_ms <= pwdata[19:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_FLOOR: prdata = {12'd0, floor_ms};
      REG_MAX_AGE: prdata = {12'd0, max_age_ms};
      default: prdata = '0;
    endcase
  end

  ast_ram #(.Width(SlotW), .Depth(NUM_SLOTS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(rd)
  );

  assign last = (idx == IdxW'(NUM_SLOTS - 1));
  wire cur_used = used[idx];
  wire key_hit = cur_used && rd.addr == cur.addr && rd.tbl == cur.addr_qual;
  wire [31:0] age = cur.now_ms - rd.seen_ms;

  // observe: modified slot
  slot_t obs;
  logic notify_c;
  always_comb begin
    logic [31:0] obs_age;
    logic speak;
    obs = rd;
    if (fresh_claim) begin
      obs = '0;
      obs.addr = cur.addr;
      obs.tbl = cur.addr_qual;
      obs.seen_ms = cur.now_ms;
    end
    if (cur.obs_key != obs.obs_key) begin
      obs.obs_key = cur.obs_key;
      obs.seen_ms = cur.now_ms;
    end
    obs.keep_ms = cur.forget_after_ms;
    obs_age = cur.now_ms - cur.obs_time_ms;
    speak = 1'b0;
    if (obs_age <= {12'd0, max_age_ms}) begin
      speak = cur.level > obs.level;
      if (cur.level < obs.level) begin
        if (!obs.falling) begin
          obs.falling = 1'b1;
          obs.falling_since = cur.now_ms;
        end else if (cur.now_ms - obs.falling_since >= {12'd0, floor_ms}) begin
          obs.level = cur.level;
          obs.falling = 1'b0;
        end
      end else begin
        obs.falling = 1'b0;
      end
      if (speak) obs.level = cur.level;
    end
    if (speak) obs.dismissed = 1'b0;
    notify_c = speak && !obs.dismissed;
  end

  // sweep modification for withdraw/dismiss/forget
  slot_t swp;
  logic swp_we, swp_clear;
  always_comb begin
    swp = rd;
    swp_we = 1'b0;
    swp_clear = 1'b0;
    unique case (op_t'(cur.op))
      OP_WITHDRAW: if (key_hit) begin
        swp.level = '0;
        swp.falling = 1'b0;
        swp.dismissed = 1'b0;
        swp_we = 1'b1;
      end
      OP_DISMISS: if (cur_used && rd.level != 2'd0) begin
        swp.dismissed = 1'b1;
        swp_we = 1'b1;
      end
      OP_FORGET: if (cur_used && age > rd.keep_ms) begin
        swp = '0;
        swp_we = 1'b1;
        swp_clear = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) begin
        priority if (op_t'(in_data.op) == OP_OBSERVE) state_next = ST_FIND_RD;
        else if (op_t'(in_data.op) == OP_WITHDRAW || op_t'(in_data.op) == OP_DISMISS
                 || op_t'(in_data.op) == OP_FORGET) state_next = ST_SWEEP_RD;
        else state_next = ST_STAT_RD;
      end
      ST_FIND_RD: state_next = ST_FIND;
      ST_FIND: if (key_hit || last) state_next = ST_OBS_RD;
               else state_next = ST_FIND_RD;
      ST_OBS_RD: state_next = ST_OBS_WR;
      ST_OBS_WR: state_next = ST_STAT_RD;
      ST_SWEEP_RD: state_next = ST_SWEEP;
      ST_SWEEP: state_next = last ? ST_STAT_RD : ST_SWEEP_RD;
      ST_STAT_RD: state_next = ST_STAT;
      ST_STAT: state_next = last ? ST_OUT : ST_STAT_RD;
      ST_OUT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wdata = obs;
    ram_addr = idx;
    unique case (state)
      ST_OBS_RD, ST_OBS_WR: begin
        ram_addr = sel;
        ram_we = (state == ST_OBS_WR);
      end
      ST_SWEEP: begin
        ram_we = swp_we;
        ram_wdata = swp;
      end
      default: ;
    endcase
    in_stall = (state != ST_IDLE);
    out_valid = (state == ST_OUT);
    out_data.notify = notify_r;
    out_data.slot_dismissed = sdis_r;
    out_data.ann_level = ann;
    out_data.all_dismissed = any_lvl && all_dis;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used <= '0;
    end else begin
      state <= state_next;
      if (state == ST_OBS_WR) used[sel] <= 1'b1;
      if (state == ST_SWEEP && swp_clear) used[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cur <= in_data;
        idx <= '0;
        have_free <= 1'b0;
        have_old <= 1'b0;
        notify_r <= 1'b0;
        sdis_r <= 1'b0;
      end
      ST_FIND: begin
        // track first free slot and oldest used slot
        if (key_hit) begin
          sel <= idx;
        end else if (!cur_used) begin
          if (!have_free) begin
            have_free <= 1'b1;
            free_i <= idx;
          end
        end else if (!have_old || age > old_age) begin
          have_old <= 1'b1;
          old_i <= idx;
          old_age <= age;
        end
        if (!key_hit && last) begin
          if (have_free || !cur_used) sel <= have_free ? free_i : idx;
          else if (!have_old || age > old_age) sel <= idx;
          else sel <= old_i;
        end
        fresh_claim <= !key_hit;
        if (!(key_hit || last)) idx <= idx + 1'b1;
      end
      ST_OBS_WR: begin
        notify_r <= notify_c;
        sdis_r <= obs.dismissed;
        idx <= '0;
      end
      ST_SWEEP: idx <= last ? '0 : idx + 1'b1;
      ST_STAT_RD: if (idx == '0) begin
        ann <= '0;
        any_lvl <= 1'b0;
        all_dis <= 1'b1;
      end
      ST_STAT: begin
        if (cur_used) begin
          if (rd.level != 2'd0) begin
            any_lvl <= 1'b1;
            if (!rd.dismissed) all_dis <= 1'b0;
          end
          if (!rd.dismissed && age <= {12'd0, max_age_ms} && rd.level > ann)
            ann <= rd.level;
        end
        if (!last) idx <= idx + 1'b1;
      end
      default: ;
    endcase
  end

  // a result is only shown while the input is stalled
  a_busy: assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("result shown while input open");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  a_notify: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.notify |-> out_data.slot_dismissed == 1'b0)
    else $error("notify on dismissed slot");
endmodule
`default_nettype wire
